// ===== design/ptt_pkg.sv =====
`default_nettype none
package ptt_pkg;

	localparam int unsigned TIME_W = 63;
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned TMO_W  = 31;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	// Cap of INT_MAX / 1000000 seconds, in ns and in us.
	localparam logic [TIME_W-1:0] CAP_NS = 63'd2147000000000;
	localparam logic [TMO_W-1:0]  CAP_US = 31'd2147000000;
	localparam int unsigned DVD_W = 41;

	// floor(x / 125) equals (x * ceil(2^45 / 125)) >> 45 for every x below 2^38.
	localparam logic [38:0] RECIP_125 = 39'd281474976711;
	localparam int unsigned RECIP_SH  = 45;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_ADD  = 2'd1,
		FUNC_DEL  = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_FIRE   = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_NEXT   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_DEL,
		S_TICK,
		S_RELOAD,
		S_NEXT,
		S_TMO,
		S_DIV,
		S_EMIT
	} state_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/ptt_req_if.sv =====
`default_nettype none
interface ptt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [62:0] now_ns;
	logic [31:0] timer_key;
	logic [62:0] initial_delay_ns;
	logic [62:0] interval_ns;

	modport source(output valid, func, now_ns, timer_key, initial_delay_ns, interval_ns,
		input ready);
	modport sink(input valid, func, now_ns, timer_key, initial_delay_ns, interval_ns,
		output ready);
endinterface
`default_nettype wire

// ===== design/ptt_rsp_if.sv =====
`default_nettype none
interface ptt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] fired_key;
	logic [1:0]  status;
	logic [30:0] next_timeout_us;
	logic        last;

	modport source(output valid, kind, fired_key, status, next_timeout_us, last,
		input ready);
	modport sink(input valid, kind, fired_key, status, next_timeout_us, last,
		output ready);
endinterface
`default_nettype wire

// ===== design/periodic_timer_table_top.sv =====
// Channel | Dir | Payload
// req     | in  | func, now_ns, timer_key, initial_delay_ns, interval_ns
// rsp     | out | kind, fired_key, status, next_timeout_us, last
//
// One shared 63-bit compare unit walks the slot table, one slot per cycle.
// Delete scans the table once; tick scans it once per fired timer and once
// more, then reloads or retires fired slots and scans for the next expiry. The
// microsecond figure is a reciprocal multiply done as four 20 by 20 bit partial
// products, one per cycle. Each result waits in the output register, and the
// sequencer stalls while that register is full and not taken.
// Reset clears all live bits at once; req is not ready until a transaction ends.
`default_nettype none
module periodic_timer_table_top
	import ptt_pkg::*;
#(
	parameter int unsigned TIMERS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	ptt_req_if.sink     req,
	ptt_rsp_if.source   rsp
);

	localparam int unsigned IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMERS - 1);

	state_t state_q, state_n, ret_q;

	logic [TIMERS-1:0] live_q;
	logic [TIMERS-1:0] fired_q;
	logic [KEY_W-1:0]  key_arr_q [TIMERS];
	logic [TIME_W-1:0] exp_arr_q [TIMERS];
	logic [TIME_W-1:0] per_arr_q [TIMERS];

	logic [TIME_W-1:0] now_q, delay_q, ivl_q;
	logic [KEY_W-1:0]  key_q;

	logic [IDX_W-1:0]  idx_q, best_idx_q;
	logic              found_q;
	logic [TIME_W-1:0] best_exp_q;
	logic [KEY_W-1:0]  best_key_q;

	logic [DVD_W-4:0]  dvd_q;
	logic [76:0]       acc_q;
	logic [1:0]        cnt_q;

	logic [1:0]        pend_kind_q, pend_status_q;
	logic [KEY_W-1:0]  pend_key_q;
	logic [TMO_W-1:0]  pend_tmo_q;
	logic              pend_last_q;

	logic              ov_q;
	logic [1:0]        o_kind_q, o_status_q;
	logic [KEY_W-1:0]  o_key_q;
	logic [TMO_W-1:0]  o_tmo_q;
	logic              o_last_q;

	// Scan datapath: one slot read, one shared compare against the best so far.
	logic [TIME_W-1:0] exp_rd, per_rd;
	logic [KEY_W-1:0]  key_rd;
	logic              cand, better, scan_last, found_n;
	logic [IDX_W-1:0]  best_idx_n;
	logic [KEY_W-1:0]  best_key_n;
	logic [TIME_W-1:0] best_exp_n;

	assign exp_rd    = exp_arr_q[idx_q];
	assign per_rd    = per_arr_q[idx_q];
	assign key_rd    = key_arr_q[idx_q];
	assign scan_last = (idx_q == IDX_LAST);

	always_comb begin
		case (state_q)
			S_DEL:   cand = live_q[idx_q] && (key_rd == key_q);
			S_TICK:  cand = live_q[idx_q] && (exp_rd <= now_q) && !fired_q[idx_q];
			default: cand = live_q[idx_q];
		endcase
		better     = cand && (!found_q || (exp_rd < best_exp_q));
		found_n    = found_q || better;
		best_idx_n = better ? idx_q : best_idx_q;
		best_key_n = better ? key_rd : best_key_q;
		best_exp_n = better ? exp_rd : best_exp_q;
	end

	// Lowest free slot for add.
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMERS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	logic [TIME_W-1:0] add_exp, reload_sum, reload_exp;
	assign add_exp    = sat_add(now_q, (delay_q != '0) ? delay_q : ivl_q);
	assign reload_sum = sat_add(exp_rd, per_rd);
	assign reload_exp = (reload_sum < now_q) ? now_q : reload_sum;

	logic              tmo_late, tmo_cap;
	logic [TIME_W-1:0] tmo_diff;
	assign tmo_late = best_exp_q < now_q;
	assign tmo_diff = best_exp_q - now_q;
	assign tmo_cap  = tmo_diff >= CAP_NS;

	// The difference over 8 is multiplied by the reciprocal of 125 in four
	// partial products, low halves first, and accumulated one per cycle.
	logic [19:0] mul_a, mul_b;
	logic [39:0] mul_p;
	logic [76:0] mul_term, acc_n;
	always_comb begin
		mul_a = cnt_q[1] ? {1'b0, dvd_q[37:19]} : {1'b0, dvd_q[18:0]};
		mul_b = cnt_q[0] ? RECIP_125[38:19] : {1'b0, RECIP_125[18:0]};
		mul_p = mul_a * mul_b;
		case (cnt_q)
			2'd0:    mul_term = 77'(mul_p);
			2'd3:    mul_term = {mul_p[38:0], 38'd0};
			default: mul_term = {18'd0, mul_p, 19'd0};
		endcase
		acc_n = acc_q + mul_term;
	end

	logic out_free, req_ready, div_done;
	assign div_done = (cnt_q == 2'd3);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.func)
						FUNC_TICK: state_n = S_TICK;
						FUNC_ADD:  state_n = S_ADD;
						FUNC_DEL:  state_n = S_DEL;
						default:   state_n = S_IDLE;
					endcase
				end
			end
			S_ADD:    state_n = S_EMIT;
			S_DEL:    state_n = scan_last ? S_EMIT : S_DEL;
			S_TICK:   state_n = scan_last ? (found_n ? S_EMIT : S_RELOAD) : S_TICK;
			S_RELOAD: state_n = scan_last ? S_NEXT : S_RELOAD;
			S_NEXT:   state_n = scan_last ? (found_n ? S_TMO : S_EMIT) : S_NEXT;
			S_TMO:    state_n = (tmo_late || tmo_cap) ? S_EMIT : S_DIV;
			S_DIV:    state_n = div_done ? S_EMIT : S_DIV;
			S_EMIT:   state_n = out_free ? ret_q : S_EMIT;
			default:  state_n = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == S_IDLE);
		out_free  = !ov_q || rsp.ready;
	end

	assign req.ready = req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			fired_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			cnt_q   <= '0;
			ret_q   <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			ov_q <= ((state_q == S_EMIT) && out_free) || (ov_q && !rsp.ready);
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						fired_q <= '0;
					end
				end
				S_ADD: begin
					ret_q <= S_IDLE;
					if (free_found && !(delay_q == '0 && ivl_q == '0)) begin
						live_q[free_idx] <= 1'b1;
					end
				end
				S_DEL, S_TICK, S_NEXT: begin
					if (scan_last) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						if (state_q == S_DEL) begin
							ret_q <= S_IDLE;
							if (found_n) live_q[best_idx_n] <= 1'b0;
						end else if (state_q == S_TICK) begin
							ret_q <= S_TICK;
							if (found_n) fired_q[best_idx_n] <= 1'b1;
						end else begin
							ret_q <= S_IDLE;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						found_q <= found_n;
					end
				end
				S_RELOAD: begin
					if (fired_q[idx_q] && per_rd == '0) live_q[idx_q] <= 1'b0;
					idx_q <= scan_last ? '0 : idx_q + 1'b1;
				end
				S_TMO: begin
					cnt_q <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					now_q   <= req.now_ns;
					key_q   <= req.timer_key;
					delay_q <= req.initial_delay_ns;
					ivl_q   <= req.interval_ns;
				end
			end
			S_ADD: begin
				pend_kind_q <= KIND_STATUS;
				pend_key_q  <= '0;
				pend_tmo_q  <= '0;
				pend_last_q <= 1'b1;
				if (delay_q == '0 && ivl_q == '0) begin
					pend_status_q <= ST_ZERO;
				end else if (!free_found) begin
					pend_status_q <= ST_FULL;
				end else begin
					pend_status_q       <= ST_OK;
					key_arr_q[free_idx] <= key_q;
					exp_arr_q[free_idx] <= add_exp;
					per_arr_q[free_idx] <= ivl_q;
				end
			end
			S_DEL, S_TICK, S_NEXT: begin
				best_idx_q <= best_idx_n;
				best_key_q <= best_key_n;
				best_exp_q <= best_exp_n;
				if (scan_last) begin
					if (state_q == S_DEL) begin
						pend_kind_q   <= KIND_STATUS;
						pend_key_q    <= '0;
						pend_status_q <= found_n ? ST_OK : ST_NOTFOUND;
						pend_tmo_q    <= '0;
						pend_last_q   <= 1'b1;
					end else if (state_q == S_TICK) begin
						pend_kind_q   <= KIND_FIRE;
						pend_key_q    <= best_key_n;
						pend_status_q <= ST_OK;
						pend_tmo_q    <= '0;
						pend_last_q   <= 1'b0;
					end else begin
						// Next-expiry report, preset to the cap, which stands if no live timer is left.
						pend_kind_q   <= KIND_NEXT;
						pend_key_q    <= '0;
						pend_status_q <= ST_OK;
						pend_tmo_q    <= CAP_US;
						pend_last_q   <= 1'b1;
					end
				end
			end
			S_RELOAD: begin
				if (fired_q[idx_q] && per_rd != '0) exp_arr_q[idx_q] <= reload_exp;
			end
			S_TMO: begin
				pend_tmo_q <= tmo_late ? '0 : CAP_US;
				dvd_q      <= tmo_diff[DVD_W-1:3];
				acc_q      <= '0;
			end
			S_DIV: begin
				acc_q <= acc_n;
				if (div_done) pend_tmo_q <= acc_n[RECIP_SH+TMO_W-1:RECIP_SH];
			end
			S_EMIT: begin
				if (out_free) begin
					o_kind_q   <= pend_kind_q;
					o_key_q    <= pend_key_q;
					o_status_q <= pend_status_q;
					o_tmo_q    <= pend_tmo_q;
					o_last_q   <= pend_last_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid           = ov_q;
	assign rsp.kind            = o_kind_q;
	assign rsp.fired_key       = o_key_q;
	assign rsp.status          = o_status_q;
	assign rsp.next_timeout_us = o_tmo_q;
	assign rsp.last            = o_last_q;

endmodule
`default_nettype wire

// ===== design/ptt_check.sv =====
`default_nettype none
module ptt_check
	import ptt_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_ready,
	input wire [1:0]  req_func,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire [1:0]  rsp_kind,
	input wire [30:0] rsp_tmo,
	input wire        rsp_last
);

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	// Accepting any operation but NOP closes the request side in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func != FUNC_NOP |=> !req_ready)
		else $error("request accepted while busy");

	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_FIRE |-> !rsp_last)
		else $error("fired timer marked last");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_STATUS |-> rsp_last)
		else $error("status result not last");

	a_next_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_NEXT |-> rsp_last && rsp_tmo <= CAP_US)
		else $error("bad next timeout report");

endmodule

bind periodic_timer_table_top ptt_check u_ptt_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_func  (req.func),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.kind),
	.rsp_tmo   (rsp.next_timeout_us),
	.rsp_last  (rsp.last)
);
`default_nettype wire
